// ===== hw/rtl/reversible_double_ended_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the reversible double-ended queue
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define REVERSIBLE_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Full form: explicit clock and reset.
`define RDEQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Short form for modules whose clock and reset are named clock and reset.
`define RDEQ_ASSERT_CLK(label, prop, msg) \
   `RDEQ_ASSERT(label, clock, reset, prop, msg)

`endif

// ===== hw/rtl/rdeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdeq_pkg
// Constants, types and helpers shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package rdeq_pkg;

   localparam int CAPACITY     = 256;
   localparam int SLOT_W       = $clog2(CAPACITY);
   localparam int COUNT_W      = $clog2(CAPACITY + 1);
   localparam int MODE_W       = 3;
   localparam int VALUE_W      = 32;
   localparam int ITEM_COUNT_W = 9;

   // Beat layouts.
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 8;
   localparam int RSP_FIELD_W = 2 * VALUE_W + ITEM_COUNT_W + 3;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_BACK_LO   = VALUE_W;
   localparam int RSP_COUNT_LO  = 2 * VALUE_W;
   localparam int RSP_EMPTY_BIT = RSP_COUNT_LO + ITEM_COUNT_W;
   localparam int RSP_FULL_BIT  = RSP_EMPTY_BIT + 1;
   localparam int RSP_DROP_BIT  = RSP_EMPTY_BIT + 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_QUERY      = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_PUSH_BACK  = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_POP_BACK   = 3'd4,
      MODE_REVERSE    = 3'd5,
      MODE_CLEAR      = 3'd6
   } mode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted request beat
      logic execute;   // apply the operation to the ring and pointers
      logic load_out;  // move the end values and flags into the output register
   } rdeq_cmd_type;

   // Reduce a sum below twice the capacity to a ring slot.
   function automatic logic [SLOT_W-1:0] slot_wrap(input logic [COUNT_W:0] sum);
      logic [COUNT_W:0] cap;
      cap = (COUNT_W + 1)'(CAPACITY);
      if (sum >= cap) begin
         return SLOT_W'(sum - cap);
      end
      return SLOT_W'(sum);
   endfunction

endpackage

// ===== hw/rtl/reversible_double_ended_queue.sv =====
`timescale 1ns / 1ps
// Sequence: a request beat is captured, the operation is applied to the store, both ends are
// read from the two-read-port ring RAM through its registered ports, and the result is loaded
// once the output register is free. No new request is accepted before that result is loaded.
// Reset (synchronous, active high) empties the queue, clears the direction flag,
// the sequencer and the output valid; the ring store itself is not cleared.
// ----------------------------------------------------------------------------
// reversible_double_ended_queue
// Bounded deque of signed 32-bit values in a ring store with O(1) reverse.
// ----------------------------------------------------------------------------
//
// Each request beat carries one operation: query, push front, push back,
// pop front, pop back, reverse, or clear. Every operation returns exactly one
// response beat with the front and back values (all ones when empty), the
// count, and the empty, full and push-dropped flags.
//
// The values sit in a ring of CAPACITY slots. The pointer first_ff marks the
// low physical end and the count gives the high end. Reverse does not move any
// data: it flips a direction flag that selects which physical end answers as
// the logical front. A reverse on an empty queue is ignored. A push to a full
// queue changes nothing and raises push_dropped in its response.
//
// The controller steps each operation through capture, execute, read and
// load. The response sits in an output register, so a pending response never
// blocks the sequencer until the next one is ready to be loaded.
module reversible_double_ended_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rdeq_pkg::REQ_TDATA_W-1:0]      req_tdata,  // [31:0] push_value
   input  logic [rdeq_pkg::REQ_TUSER_W-1:0]      req_tuser,  // [2:0] mode, rest zero
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] front_value, [63:32] back_value, [72:64] item_count,
   // [73] is_empty, [74] is_full, [75] push_dropped, [79:76] zero
   output logic [rdeq_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   rdeq_pkg::rdeq_cmd_type                  cmd;
   logic signed [rdeq_pkg::VALUE_W-1:0]     front_value;
   logic signed [rdeq_pkg::VALUE_W-1:0]     back_value;
   logic [rdeq_pkg::ITEM_COUNT_W-1:0]       item_count;
   logic                                    is_empty;
   logic                                    is_full;
   logic                                    push_dropped;

   // The sequencer owns the handshakes; the datapath only sees commands.
   rdeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath holds the ring, the pointers and the response register.
   rdeq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_tuser[rdeq_pkg::MODE_W-1:0]),
      .req_push_value   (req_tdata[rdeq_pkg::VALUE_W-1:0]),
      .rsp_front_value  (front_value),
      .rsp_back_value   (back_value),
      .rsp_item_count   (item_count),
      .rsp_is_empty     (is_empty),
      .rsp_is_full      (is_full),
      .rsp_push_dropped (push_dropped)
   );

   // Pack the response fields from the lowest bit up and pad to whole bytes.
   assign rsp_tdata = rdeq_pkg::RSP_TDATA_W'({push_dropped, is_full, is_empty,
                                              item_count, back_value, front_value});

endmodule

// ===== hw/rtl/rdeq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdeq_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rdeq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hw/rtl/rdeq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdeq_ctrl
// Sequencer for one operation: capture, execute, read ends, load result.
// ----------------------------------------------------------------------------
module rdeq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output rdeq_pkg::rdeq_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_READ = 4'b0100,
      S_LOAD = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // Wait here until the output register is empty or being drained.
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/rdeq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdeq_datapath
// Ring store, end pointers, direction flag and the result register.
// ----------------------------------------------------------------------------
module rdeq_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  rdeq_pkg::rdeq_cmd_type                    cmd,
   input  logic [rdeq_pkg::MODE_W-1:0]               req_mode,
   input  logic signed [rdeq_pkg::VALUE_W-1:0]       req_push_value,
   output logic signed [rdeq_pkg::VALUE_W-1:0]       rsp_front_value,
   output logic signed [rdeq_pkg::VALUE_W-1:0]       rsp_back_value,
   output logic [rdeq_pkg::ITEM_COUNT_W-1:0]         rsp_item_count,
   output logic                                      rsp_is_empty,
   output logic                                      rsp_is_full,
   output logic                                      rsp_push_dropped
);

   // Captured request.
   logic [rdeq_pkg::MODE_W-1:0]         op_mode_ff;
   logic [rdeq_pkg::VALUE_W-1:0]        op_value_ff;

   // Queue state.
   logic [rdeq_pkg::SLOT_W-1:0]         first_ff, first_in;
   logic [rdeq_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic                                rev_ff, rev_in;
   logic                                dropped_ff, dropped_in;

   // Result register.
   logic [rdeq_pkg::VALUE_W-1:0]        front_ff, back_ff;
   logic [rdeq_pkg::ITEM_COUNT_W-1:0]   item_count_ff;
   logic                                empty_ff, full_ff, drop_out_ff;

   logic                                is_full_now;
   logic                                is_empty_now;
   logic                                to_low;
   logic                                from_low;
   logic [rdeq_pkg::SLOT_W-1:0]         slot_dec;
   logic [rdeq_pkg::SLOT_W-1:0]         slot_inc;
   logic [rdeq_pkg::COUNT_W:0]          end_sum;
   logic [rdeq_pkg::SLOT_W-1:0]         tail_slot;
   logic [rdeq_pkg::SLOT_W-1:0]         last_slot;
   logic                                wr_en;
   logic [rdeq_pkg::SLOT_W-1:0]         wr_addr;
   logic [rdeq_pkg::VALUE_W-1:0]        lo_data, hi_data;

   assign is_full_now  = (count_ff == rdeq_pkg::COUNT_W'(rdeq_pkg::CAPACITY));
   assign is_empty_now = (count_ff == '0);
   assign to_low   = (op_mode_ff == rdeq_pkg::MODE_PUSH_FRONT) != rev_ff;
   assign from_low = (op_mode_ff == rdeq_pkg::MODE_POP_FRONT) != rev_ff;

   assign slot_dec = (first_ff == '0) ? rdeq_pkg::SLOT_W'(rdeq_pkg::CAPACITY - 1)
                                      : first_ff - 1'b1;
   assign slot_inc = (first_ff == rdeq_pkg::SLOT_W'(rdeq_pkg::CAPACITY - 1)) ? '0
                                      : first_ff + 1'b1;
   assign end_sum   = (rdeq_pkg::COUNT_W + 1)'(first_ff)
                    + (rdeq_pkg::COUNT_W + 1)'(count_ff);
   // Slot just past the high end, and the high end itself.
   assign tail_slot = rdeq_pkg::slot_wrap(end_sum);
   assign last_slot = rdeq_pkg::slot_wrap(end_sum - 1'b1);

   always_comb begin
      first_in   = first_ff;
      count_in   = count_ff;
      rev_in     = rev_ff;
      dropped_in = dropped_ff;
      wr_en      = 1'b0;
      wr_addr    = tail_slot;
      if (cmd.execute) begin
         dropped_in = 1'b0;
         unique case (op_mode_ff) inside
            rdeq_pkg::MODE_PUSH_FRONT, rdeq_pkg::MODE_PUSH_BACK: begin
               if (is_full_now) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (to_low) begin
                     wr_addr  = slot_dec;
                     first_in = slot_dec;
                  end
               end
            end
            rdeq_pkg::MODE_POP_FRONT, rdeq_pkg::MODE_POP_BACK: begin
               if (!is_empty_now) begin
                  count_in = count_ff - 1'b1;
                  if (from_low) begin
                     first_in = slot_inc;
                  end
               end
            end
            rdeq_pkg::MODE_REVERSE: begin
               if (!is_empty_now) begin
                  rev_in = !rev_ff;
               end
            end
            rdeq_pkg::MODE_CLEAR: begin
               first_in = '0;
               count_in = '0;
               rev_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   rdeq_ram #(
      .WIDTH (rdeq_pkg::VALUE_W),
      .DEPTH (rdeq_pkg::CAPACITY)
   ) u_ring (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (op_value_ff),
      .rd_addr_a (first_ff),
      .rd_data_a (lo_data),
      .rd_addr_b (last_slot),
      .rd_data_b (hi_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= '0;
         count_ff   <= '0;
         rev_ff     <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         first_ff   <= first_in;
         count_ff   <= count_in;
         rev_ff     <= rev_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_mode_ff  <= req_mode;
         op_value_ff <= req_push_value;
      end
      if (cmd.load_out) begin
         if (is_empty_now) begin
            front_ff <= '1;
            back_ff  <= '1;
         end else begin
            front_ff <= rev_ff ? hi_data : lo_data;
            back_ff  <= rev_ff ? lo_data : hi_data;
         end
         item_count_ff <= rdeq_pkg::ITEM_COUNT_W'(count_ff);
         empty_ff      <= is_empty_now;
         full_ff       <= is_full_now;
         drop_out_ff   <= dropped_ff;
      end
   end

   assign rsp_front_value  = front_ff;
   assign rsp_back_value   = back_ff;
   assign rsp_item_count   = item_count_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_is_full      = full_ff;
   assign rsp_push_dropped = drop_out_ff;

endmodule

// ===== hw/rtl/rdeq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdeq_checker
// Port-level checks on the response beats of the double-ended queue.
// ----------------------------------------------------------------------------
`include "reversible_double_ended_queue_assert.svh"

module rdeq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rdeq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic [rdeq_pkg::ITEM_COUNT_W-1:0] count_field;
   logic                              empty_field;
   logic                              full_field;
   logic                              drop_field;
   logic [2*rdeq_pkg::VALUE_W-1:0]    ends_field;

   assign count_field = rdeq_pkg::ITEM_COUNT_W'(rsp_tdata >> rdeq_pkg::RSP_COUNT_LO);
   assign empty_field = rsp_tdata[rdeq_pkg::RSP_EMPTY_BIT];
   assign full_field  = rsp_tdata[rdeq_pkg::RSP_FULL_BIT];
   assign drop_field  = rsp_tdata[rdeq_pkg::RSP_DROP_BIT];
   assign ends_field  = rsp_tdata[2*rdeq_pkg::VALUE_W-1:0];

   `RDEQ_ASSERT_CLK(a_empty_matches_count,
      rsp_tvalid |-> (empty_field == (count_field == '0)),
      "is_empty disagrees with item_count")

   `RDEQ_ASSERT_CLK(a_empty_ends_all_ones,
      (rsp_tvalid && empty_field) |-> (ends_field == '1),
      "empty queue must report -1 at both ends")

   `RDEQ_ASSERT_CLK(a_full_matches_count,
      (rsp_tvalid && full_field) |->
         (count_field == rdeq_pkg::ITEM_COUNT_W'(rdeq_pkg::CAPACITY)),
      "is_full set while item_count is below capacity")

   `RDEQ_ASSERT_CLK(a_drop_only_when_full,
      (rsp_tvalid && drop_field) |-> (full_field && !empty_field),
      "push_dropped reported on a queue that is not full")

   `RDEQ_ASSERT_CLK(a_rsp_holds_when_stalled,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)),
      "stalled response beat changed or vanished")

endmodule

bind reversible_double_ended_queue rdeq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
